FILE: rtl/core/cst_pkg.sv
package cst_pkg;

  // field widths fixed by the item formats
  localparam int MARK_BITS = 10;
  localparam int OP_W      = 2;
  localparam int COL_W     = 4;
  localparam int CC_W      = 5;
  localparam int SUM_W     = 20;
  localparam int SQ_W      = 30;
  localparam int OUT_W     = 10;
  // column counts are compared in this width (covers up to 127 columns)
  localparam int NCW       = 7;

  localparam logic [OUT_W-1:0]     OUT_LIMIT = '1;
  localparam logic [MARK_BITS-1:0] MARK_MASK = '1;

  // request operations
  localparam logic [OP_W-1:0] OP_SET  = 2'd0;
  localparam logic [OP_W-1:0] OP_MARK = 2'd1;
  localparam logic [OP_W-1:0] OP_FIN  = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]      operation;
    logic [COL_W-1:0]     column;
    logic [MARK_BITS-1:0] value;
    logic                 end_of_row;
  } in_item_t;

  typedef struct packed {
    logic [COL_W-1:0] column_res;
    logic [OUT_W-1:0] maximum;
    logic [OUT_W-1:0] minimum;
    logic [OUT_W-1:0] average;
    logic [OUT_W-1:0] std_dev;
    logic             no_data;
    logic             last;
  } out_item_t;

  typedef struct packed {
    logic [MARK_BITS-1:0] max_v;
    logic [MARK_BITS-1:0] min_v;
    logic [SUM_W-1:0]     sum;
    logic [SQ_W-1:0]      sq_sum;
  } entry_t;

  typedef struct packed {
    logic load_item;
    logic upd;
    logic fin_first;
    logic fin_next;
    logic rd_fin;
    logic div_mean;
    logic div_var;
    logic mul1;
    logic mul2;
    logic var_calc;
    logic sqrt_start;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic no_data;
    logic last_col;
    logic div_done;
    logic sqrt_done;
    logic out_free;
  } sts_t;

endpackage

FILE: rtl/core/cst_div.sv
module cst_div #(
  parameter int DW = 42,
  parameter int RW = 17
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [RW-1:0] divisor,
  output logic          busy,
  output logic          done,
  output logic [DW-1:0] quot
);

  localparam int CW = $clog2(DW + 1);

  logic [RW-1:0] rem_r, rem_nxt;
  logic [DW-1:0] quo_r;
  logic [RW-1:0] dvs_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic          done_r;
  logic [RW:0]   shifted;
  logic          q_bit;

  // one restoring step per cycle
  always_comb begin
    shifted = {rem_r, quo_r[DW-1]};
    q_bit   = (shifted >= {1'b0, dvs_r});
    rem_nxt = q_bit ? RW'(shifted - {1'b0, dvs_r}) : shifted[RW-1:0];
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(DW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // operands and partial results
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= {quo_r[DW-2:0], q_bit};
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign quot = quo_r;

endmodule

FILE: rtl/core/cst_sqrt.sv
module cst_sqrt #(
  parameter int XW = 42
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [XW-1:0]   x,
  output logic            done,
  output logic [XW/2-1:0] root
);

  localparam int RW = XW / 2;
  localparam int CW = $clog2(RW + 1);

  logic [XW-1:0] x_r;
  logic [RW:0]   rem_r;
  logic [RW-1:0] root_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic          done_r;
  logic [RW+2:0] trial_rem;
  logic [RW+2:0] trial;
  logic          r_bit;

  // one result bit per cycle, two input bits brought down
  always_comb begin
    trial_rem = {rem_r, x_r[XW-1:XW-2]};
    trial     = {1'b0, root_r, 2'b01};
    r_bit     = (trial_rem >= trial);
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(RW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      x_r    <= x;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      x_r    <= {x_r[XW-3:0], 2'b00};
      rem_r  <= r_bit ? (RW+1)'(trial_rem - trial) : trial_rem[RW:0];
      root_r <= {root_r[RW-2:0], r_bit};
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule

FILE: rtl/core/cst_ctrl.sv
module cst_ctrl
  import cst_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic [OP_W-1:0] in_op,
  output logic            in_stall,
  input  sts_t            sts,
  output cmd_t            cmd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_UPD   = 4'd1;
  localparam logic [3:0] S_FRD   = 4'd2;
  localparam logic [3:0] S_FEV   = 4'd3;
  localparam logic [3:0] S_DIV1  = 4'd4;
  localparam logic [3:0] S_MUL1  = 4'd5;
  localparam logic [3:0] S_MUL2  = 4'd6;
  localparam logic [3:0] S_VAR   = 4'd7;
  localparam logic [3:0] S_DIV2S = 4'd8;
  localparam logic [3:0] S_DIV2  = 4'd9;
  localparam logic [3:0] S_SQRT  = 4'd10;
  localparam logic [3:0] S_OUT   = 4'd11;

  logic [3:0] state_r, state_nxt;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load_item = 1'b1;
          unique case (in_op)
            OP_SET, OP_MARK: state_nxt = S_UPD;
            OP_FIN: begin
              cmd.fin_first = 1'b1;
              state_nxt     = S_FRD;
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_UPD: begin
        cmd.upd   = 1'b1;
        state_nxt = S_IDLE;
      end
      S_FRD: begin
        cmd.rd_fin = 1'b1;
        state_nxt  = S_FEV;
      end
      S_FEV: begin
        if (sts.no_data) begin
          state_nxt = S_OUT;
        end else begin
          cmd.div_mean = 1'b1;
          state_nxt    = S_DIV1;
        end
      end
      S_DIV1: begin
        if (sts.div_done) state_nxt = S_MUL1;
      end
      S_MUL1: begin
        cmd.mul1  = 1'b1;
        state_nxt = S_MUL2;
      end
      S_MUL2: begin
        cmd.mul2  = 1'b1;
        state_nxt = S_VAR;
      end
      S_VAR: begin
        cmd.var_calc = 1'b1;
        state_nxt    = S_DIV2S;
      end
      S_DIV2S: begin
        cmd.div_var = 1'b1;
        state_nxt   = S_DIV2;
      end
      S_DIV2: begin
        if (sts.div_done) begin
          cmd.sqrt_start = 1'b1;
          state_nxt      = S_SQRT;
        end
      end
      S_SQRT: begin
        if (sts.sqrt_done) state_nxt = S_OUT;
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          if (sts.last_col) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.fin_next = 1'b1;
            state_nxt    = S_FRD;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: rtl/core/cst_dp.sv
module cst_dp
  import cst_pkg::*;
#(
  parameter int MAX_COLUMNS = 16,
  parameter int MAX_ROWS    = 1024
) (
  input  logic            clk,
  input  logic            rst_n,
  input  in_item_t        in_data,
  input  cmd_t            cmd,
  output sts_t            sts,
  output logic            out_valid,
  input  logic            out_stall,
  output out_item_t       out_data,
  input  logic            cfg_wr_en,
  input  logic [CC_W-1:0] cfg_wr_data
);

  localparam int CIW  = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int RCW  = $clog2(MAX_ROWS + 1);
  localparam int PW   = 2 * SUM_W;
  localparam int VARW = PW + 3;
  localparam int DVW  = PW + 2;
  localparam int RTW  = DVW / 2;

  logic [CC_W-1:0]        col_cnt_r;
  in_item_t               item_r;
  entry_t                 mem [MAX_COLUMNS];
  logic [MAX_COLUMNS-1:0] vld_r;
  entry_t                 rd_data_r;
  logic [RCW-1:0]         row_cnt_r;
  logic [NCW-1:0]         k_r;
  logic [SUM_W-1:0]       mean_r;
  logic [SUM_W-1:0]       t_r;
  logic [PW-1:0]          p1_r;
  logic [PW-1:0]          tm_r;
  logic [DVW-1:0]         var_r;
  out_item_t              out_r;
  logic                   out_valid_r;

  logic [NCW-1:0]         n_cols;
  logic [NCW-1:0]         cc_ext;
  logic [NCW-1:0]         in_col_ext;
  logic [NCW-1:0]         it_col_ext;
  logic                   col_ok;
  logic                   rd_en;
  logic [CIW-1:0]         rd_addr;
  entry_t                 new_ent;
  logic [MARK_BITS-1:0]   v;
  logic [SUM_W:0]         sum_ext;
  logic [SQ_W:0]          sq_ext;
  logic [2*MARK_BITS-1:0] vv;
  logic                   div_start;
  logic                   div_busy;
  logic                   div_done;
  logic [DVW-1:0]         div_q;
  logic [DVW-1:0]         div_a;
  logic                   sqrt_done;
  logic [RTW-1:0]         root;
  logic [SUM_W-1:0]       mean_q;
  logic [RCW+SUM_W-1:0]   nm;
  logic [VARW-1:0]        var_full;
  logic                   no_data;
  logic                   out_free;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_cnt_r <= CC_W'(1);
    end else if (cfg_wr_en) begin
      col_cnt_r <= cfg_wr_data;
    end
  end

  // columns in use, clamped to one and to the store depth
  always_comb begin
    cc_ext = {{(NCW-CC_W){1'b0}}, col_cnt_r};
    priority if (cc_ext == '0) begin
      n_cols = NCW'(1);
    end else if (cc_ext > NCW'(MAX_COLUMNS)) begin
      n_cols = NCW'(MAX_COLUMNS);
    end else begin
      n_cols = cc_ext;
    end
  end

  assign in_col_ext = {{(NCW-COL_W){1'b0}}, in_data.column};
  assign it_col_ext = {{(NCW-COL_W){1'b0}}, item_r.column};
  assign col_ok     = it_col_ext < n_cols;

  // request capture
  always_ff @(posedge clk) begin
    if (cmd.load_item) item_r <= in_data;
  end

  // statistics store, registered read
  assign rd_en   = cmd.load_item | cmd.rd_fin;
  assign rd_addr = cmd.rd_fin ? k_r[CIW-1:0] : in_col_ext[CIW-1:0];

  always_ff @(posedge clk) begin
    if (rd_en) rd_data_r <= vld_r[rd_addr] ? mem[rd_addr] : '0;
  end

  always_ff @(posedge clk) begin
    if (cmd.upd && col_ok) mem[it_col_ext[CIW-1:0]] <= new_ent;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (cmd.upd && col_ok) begin
      vld_r[it_col_ext[CIW-1:0]] <= 1'b1;
    end
  end

  // read-modify-write of one column
  always_comb begin
    v       = item_r.value & MARK_MASK;
    vv      = v * v;
    sum_ext = {1'b0, rd_data_r.sum} + {{(SUM_W+1-MARK_BITS){1'b0}}, v};
    sq_ext  = {1'b0, rd_data_r.sq_sum} + {{(SQ_W+1-2*MARK_BITS){1'b0}}, vv};
    if (item_r.operation == OP_SET) begin
      new_ent.max_v  = '0;
      new_ent.min_v  = v;
      new_ent.sum    = '0;
      new_ent.sq_sum = '0;
    end else begin
      new_ent.max_v  = (v > rd_data_r.max_v) ? v : rd_data_r.max_v;
      new_ent.min_v  = (v < rd_data_r.min_v) ? v : rd_data_r.min_v;
      new_ent.sum    = sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];
      new_ent.sq_sum = sq_ext[SQ_W] ? '1 : sq_ext[SQ_W-1:0];
    end
  end

  // row counter, saturating
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_cnt_r <= '0;
    end else if (cmd.upd && item_r.operation == OP_MARK && item_r.end_of_row &&
                 row_cnt_r < RCW'(MAX_ROWS)) begin
      row_cnt_r <= row_cnt_r + 1'b1;
    end
  end

  // column walk
  always_ff @(posedge clk) begin
    if (cmd.fin_first) begin
      k_r <= '0;
    end else if (cmd.fin_next) begin
      k_r <= k_r + 1'b1;
    end
  end

  // shared divider: mean first, then variance over the row count
  assign div_start = cmd.div_mean | cmd.div_var;
  assign div_a     = cmd.div_var ? var_r : {{(DVW-SUM_W){1'b0}}, rd_data_r.sum};

  cst_div #(
    .DW (DVW),
    .RW (RCW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (row_cnt_r),
    .busy     (div_busy),
    .done     (div_done),
    .quot     (div_q)
  );

  cst_sqrt #(
    .XW (DVW)
  ) u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.sqrt_start),
    .x     (div_q),
    .done  (sqrt_done),
    .root  (root)
  );

  // mean never exceeds the sum, and n*mean never exceeds it either
  assign mean_q = div_q[SUM_W-1:0];
  assign nm     = {{SUM_W{1'b0}}, row_cnt_r} * {{RCW{1'b0}}, mean_q};

  // variance rebuilt as sumsq - 2*mean*sum + n*mean*mean
  always_ff @(posedge clk) begin
    if (cmd.mul1) begin
      mean_r <= mean_q;
      p1_r   <= mean_q * rd_data_r.sum;
      t_r    <= nm[SUM_W-1:0];
    end
    if (cmd.mul2) tm_r <= t_r * mean_r;
    if (cmd.var_calc) var_r <= var_full[VARW-1] ? '0 : var_full[DVW-1:0];
  end

  assign var_full = {{(VARW-SQ_W){1'b0}}, rd_data_r.sq_sum}
                  - {2'b00, p1_r, 1'b0}
                  + {3'b000, tm_r};

  // result register
  assign no_data  = row_cnt_r == '0;
  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_r.column_res <= k_r[COL_W-1:0];
      out_r.maximum    <= rd_data_r.max_v;
      out_r.minimum    <= rd_data_r.min_v;
      out_r.no_data    <= no_data;
      out_r.last       <= sts.last_col;
      if (no_data) begin
        out_r.average <= '0;
        out_r.std_dev <= '0;
      end else begin
        out_r.average <= (mean_r > SUM_W'(OUT_LIMIT)) ? OUT_LIMIT : mean_r[OUT_W-1:0];
        out_r.std_dev <= (root > RTW'(OUT_LIMIT)) ? OUT_LIMIT : root[OUT_W-1:0];
      end
    end
  end

  // status to the controller
  assign sts.no_data   = no_data;
  assign sts.last_col  = (k_r + 1'b1) == n_cols;
  assign sts.div_done  = div_done;
  assign sts.sqrt_done = sqrt_done;
  assign sts.out_free  = out_free;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // row count stays within its ceiling
  a_row_cnt_limit: assert property (@(posedge clk) disable iff (!rst_n)
    row_cnt_r <= RCW'(MAX_ROWS))
    else $error("row count above ceiling");

  // a result is only loaded when the slot is free
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!out_valid_r || !out_stall))
    else $error("result overwritten");

  // the divider is never restarted while it works
  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_busy)
    else $error("divider restarted while busy");

  // a new request is never taken while a column walk issues reads
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd_fin |-> !cmd.load_item)
    else $error("request taken during column walk");

endmodule

FILE: rtl/core/column_statistics.sv
// column_statistics: per-column min, max, mean and standard deviation of
// integer marks.
// Requests enter on in_valid/in_stall with an in_item_t payload: set the full
// mark of a column (clears its statistics), add a mark (end_of_row counts a
// row) or finish. A finish request sends one out_item_t per column in use on
// out_valid/out_stall, the final one with last set. cfg_wr_en/cfg_wr_data
// write the number of columns in use; write it only while the block is idle.
// Set and mark requests first read the column's entry, then write it back;
// in_stall is high during the write-back.
// Finish walks the columns one by one through a shared bit-serial divider and
// square root unit; when no rows were counted, a column skips both and goes
// straight to its result.
// The result register lets the walk finish computing the next column while a
// result waits; the walk pauses while out_stall holds that register full.
// Reset (rst_n, synchronous) clears the statistics, the row count and the
// result register, and sets the column count to one.
module column_statistics
  import cst_pkg::*;
#(
  parameter int MAX_COLUMNS = 16,
  parameter int MAX_ROWS    = 1024
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  in_item_t        in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output out_item_t       out_data,
  input  logic            cfg_wr_en,
  input  logic [CC_W-1:0] cfg_wr_data
);

  cmd_t cmd;
  sts_t sts;

  // sequencer
  cst_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_op    (in_data.operation),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // stores and arithmetic
  cst_dp #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_data     (in_data),
    .cmd         (cmd),
    .sts         (sts),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

endmodule

FILE: verif/column_statistics_test.sv
module column_statistics_test;
  import cst_pkg::*;

  // operation code with no meaning
  localparam logic [OP_W-1:0] OP_NONE = 2'd3;

  logic            clk = 1'b0;
  logic            rst_n = 1'b0;
  logic            in_valid = 1'b0;
  logic            in_stall;
  in_item_t        in_data = '0;
  logic            out_valid;
  logic            out_stall = 1'b0;
  out_item_t       out_data;
  logic            cfg_wr_en = 1'b0;
  logic [CC_W-1:0] cfg_wr_data = '0;

  column_statistics dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  always #6 clk = ~clk;

  // predicted statistics state
  logic [MARK_BITS-1:0] col_max [16];
  logic [MARK_BITS-1:0] col_min [16];
  logic [SUM_W-1:0]     col_sum [16];
  logic [SQ_W-1:0]      col_sq  [16];
  logic [10:0]          rows_seen;
  logic [CC_W-1:0]      cols_reg;

  out_item_t stats_q [$];
  int errors = 0;
  int results_seen = 0;
  int requests_done = 0;
  int send_idle = 0;
  int recv_idle = 0;
  int hold_cycles = 0;

  function automatic longint floor_root(longint x);
    longint r, t;
    r = 0;
    for (int b = 20; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= x) r = t;
    end
    return r;
  endfunction

  // fold one accepted request into the predicted state
  task automatic fold_request(in_item_t it);
    int n;
    longint m, v, s, q, sd;
    out_item_t r;
    n = (cols_reg == 0) ? 1 : ((cols_reg > 16) ? 16 : int'(cols_reg));
    case (it.operation)
      OP_SET: begin
        if (it.column < n) begin
          col_max[it.column] = '0;
          col_min[it.column] = it.value;
          col_sum[it.column] = '0;
          col_sq[it.column]  = '0;
        end
      end
      OP_MARK: begin
        if (it.column < n) begin
          if (it.value > col_max[it.column]) col_max[it.column] = it.value;
          if (it.value < col_min[it.column]) col_min[it.column] = it.value;
          s = longint'(col_sum[it.column]) + longint'(it.value);
          col_sum[it.column] = (s > 64'hFFFFF) ? '1 : s[SUM_W-1:0];
          q = longint'(col_sq[it.column]) + longint'(it.value) * longint'(it.value);
          col_sq[it.column] = (q > 64'h3FFFFFFF) ? '1 : q[SQ_W-1:0];
        end
        if (it.end_of_row && rows_seen < 1024) rows_seen = rows_seen + 1'b1;
      end
      OP_FIN: begin
        for (int k = 0; k < n; k++) begin
          r = '0;
          r.column_res = COL_W'(k);
          r.maximum = col_max[k];
          r.minimum = col_min[k];
          r.no_data = (rows_seen == 0);
          r.last = (k + 1 == n);
          if (rows_seen != 0) begin
            m = longint'(col_sum[k]) / longint'(rows_seen);
            v = longint'(col_sq[k]) - 2 * m * longint'(col_sum[k])
                + longint'(rows_seen) * m * m;
            if (v < 0) v = 0;
            sd = floor_root(v / longint'(rows_seen));
            r.average = (m > 1023) ? OUT_LIMIT : m[OUT_W-1:0];
            r.std_dev = (sd > 1023) ? OUT_LIMIT : sd[OUT_W-1:0];
          end
          stats_q.push_back(r);
        end
      end
      default: ;
    endcase
  endtask

  task automatic compare_stats(out_item_t e, out_item_t a);
    if (a.column_res !== e.column_res) begin
      $error("column_res expected %0d got %0d", e.column_res, a.column_res); errors++;
    end
    if (a.maximum !== e.maximum) begin
      $error("maximum expected %0d got %0d", e.maximum, a.maximum); errors++;
    end
    if (a.minimum !== e.minimum) begin
      $error("minimum expected %0d got %0d", e.minimum, a.minimum); errors++;
    end
    if (a.average !== e.average) begin
      $error("average expected %0d got %0d", e.average, a.average); errors++;
    end
    if (a.std_dev !== e.std_dev) begin
      $error("std_dev expected %0d got %0d", e.std_dev, a.std_dev); errors++;
    end
    if (a.no_data !== e.no_data) begin
      $error("no_data expected %0d got %0d", e.no_data, a.no_data); errors++;
    end
    if (a.last !== e.last) begin
      $error("last expected %0d got %0d", e.last, a.last); errors++;
    end
  endtask

  // monitor: predict on accepted requests, check accepted results
  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 16; i++) begin
        col_max[i] = '0; col_min[i] = '0; col_sum[i] = '0; col_sq[i] = '0;
      end
      rows_seen = '0;
      cols_reg = 5'd1;
    end else begin
      if (cfg_wr_en) cols_reg = cfg_wr_data;
      if (in_valid && !in_stall) begin
        fold_request(in_data);
        requests_done++;
      end
      if (out_valid && !out_stall) begin
        results_seen++;
        if (stats_q.size() == 0) begin
          $error("result for column %0d with nothing expected", out_data.column_res);
          errors++;
        end else begin
          compare_stats(stats_q.pop_front(), out_data);
        end
      end
    end
  end

  // receiver stall, with an optional long hold-off
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle);
    end
  end

  task automatic send_request(in_item_t it);
    bit taken;
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    taken = 0;
    while (!taken) begin
      @(posedge clk);
      taken = !in_stall;
      @(negedge clk);
    end
  endtask

  // wait for every expected result, then let the block settle
  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (stats_q.size() != 0) @(negedge clk);
    repeat (30) @(negedge clk);
  endtask

  task automatic write_columns(logic [CC_W-1:0] cnt);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= cnt;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
  endtask

  function automatic in_item_t make_req(logic [OP_W-1:0] op, int col, int val, bit eor);
    in_item_t it;
    it.operation = op;
    it.column = COL_W'(col);
    it.value = MARK_BITS'(val);
    it.end_of_row = eor;
    return it;
  endfunction

  // a table: full marks, rows of marks, some noise, then finish
  task automatic random_table(int ncols, int nrows, ref int sent);
    in_item_t it;
    logic [31:0] rnd;
    for (int c = 0; c < ncols; c++) begin
      send_request(make_req(OP_SET, c, $urandom_range(1023), 1'($urandom_range(1))));
      sent++;
    end
    for (int r = 0; r < nrows; r++) begin
      for (int c = 0; c < ncols; c++) begin
        if ($urandom_range(9) == 0) begin
          rnd = $urandom;
          it = rnd[$bits(in_item_t)-1:0];
          send_request(it);
          sent++;
        end
        send_request(make_req(OP_MARK, c, $urandom_range(1023), c == ncols - 1));
        sent++;
      end
    end
    send_request(make_req(OP_FIN, $urandom_range(15), $urandom_range(1023),
                          1'($urandom_range(1))));
    sent++;
  endtask

  typedef struct {
    in_item_t  req;
    bit        typed;
    out_item_t stats;
  } row_t;

  row_t steps [9];
  int sent;
  int n_tables;

  initial begin
    // directed rows with one column in use
    steps[0] = '{make_req(OP_FIN, 0, 0, 0), 1, '{4'd0, 10'd0, 10'd0, 10'd0, 10'd0, 1'b1, 1'b1}};
    steps[1] = '{make_req(OP_SET, 0, 1023, 0), 0, '0};
    steps[2] = '{make_req(OP_FIN, 0, 0, 0), 1,
                 '{4'd0, 10'd0, 10'd1023, 10'd0, 10'd0, 1'b1, 1'b1}};
    steps[3] = '{make_req(OP_MARK, 0, 1023, 1), 0, '0};
    steps[4] = '{make_req(OP_MARK, 0, 0, 1), 0, '0};
    steps[5] = '{make_req(OP_FIN, 15, 1023, 1), 1,
                 '{4'd0, 10'd1023, 10'd0, 10'd511, 10'd511, 1'b0, 1'b1}};
    steps[6] = '{make_req(OP_MARK, 5, 7, 1), 0, '0};
    steps[7] = '{make_req(OP_NONE, 15, 1023, 1), 0, '0};
    steps[8] = '{make_req(OP_FIN, 0, 0, 0), 0, '0};

    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int i = 0; i < 9; i++) begin
      send_request(steps[i].req);
      if (steps[i].typed && stats_q[$] != steps[i].stats) begin
        $error("directed row %0d: predicted %h, table %h", i, stats_q[$], steps[i].stats);
        errors++;
      end
    end

    // zero columns acts as one, with a request to an unused column; then full width
    write_columns(5'd0);
    send_request(make_req(OP_MARK, 1, 300, 1));
    send_request(make_req(OP_FIN, 0, 0, 0));
    write_columns(5'd16);
    send_request(make_req(OP_SET, 15, 0, 0));
    send_request(make_req(OP_MARK, 15, 1023, 0));
    send_request(make_req(OP_SET, 3, 1023, 1));
    send_request(make_req(OP_MARK, 3, 512, 1));
    send_request(make_req(OP_FIN, 0, 0, 0));

    // a run of full marks on one column
    write_columns(5'd1);
    send_request(make_req(OP_SET, 0, 1023, 0));
    for (int i = 0; i < 10; i++) send_request(make_req(OP_MARK, 0, 1023, 1));
    send_request(make_req(OP_FIN, 0, 0, 0));

    // random tables over three idling phases
    sent = 0;
    n_tables = 0;
    for (int ph = 0; ph < 3; ph++) begin
      send_idle = (ph == 0) ? 10 : ((ph == 1) ? 51 : 0);
      recv_idle = (ph == 0) ? 51 : ((ph == 1) ? 10 : 0);
      while (sent < 55 * (ph + 1)) begin
        case (n_tables % 4)
          0: write_columns(5'd16);
          1: write_columns(5'd31);
          2: write_columns(5'd1);
          default: write_columns(CC_W'($urandom_range(31)));
        endcase
        if (ph == 0 && n_tables == 0) begin
          // long receiver hold while finish results pile up
          random_table(3, 2, sent);
          hold_cycles = 400;
          random_table(3, 2, sent);
        end else begin
          random_table(cols_reg == 0 ? 1 : (cols_reg > 16 ? 16 : cols_reg),
                       $urandom_range(0, 4), sent);
        end
        n_tables++;
      end
    end

    drain();
    repeat (200) @(negedge clk);
    $display("covered %0d requests, %0d results over %0d random tables",
             requests_done, results_seen, n_tables);
    $display("with column counts 0, 1, 16, 31 and random, and a run of full marks");
    if (errors == 0 && stats_q.size() == 0) begin
      $display("column_statistics_test: done, clean");
    end else begin
      $display("column_statistics_test: done, errors");
    end
    $finish;
  end

  initial begin
    #60000000;
    $display("column_statistics_test: done, errors");
    $finish;
  end

endmodule
